[src/srt_pkg.sv]
`timescale 1ns / 1ps

package srt_pkg;

    localparam int KEY_W    = 16;
    localparam int GRADE_W  = 8;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        action_t              action;
        logic [KEY_W-1:0]     key;
        logic [GRADE_W-1:0]   grade;
        logic [POS_W-1:0]     position;
    } in_beat_t;

    typedef struct packed {
        status_t              status;
        logic [KEY_W-1:0]     key_out;
        logic [GRADE_W-1:0]   grade_out;
        logic [COUNT_W-1:0]   entry_count;
    } out_beat_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } ctrl_cmd_t;

endpackage

[src/srt_ctrl.sv]
`timescale 1ns / 1ps

module srt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output srt_pkg::ctrl_cmd_t cmd
);
    import srt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   upd_go;
    logic   accept;

    // commit only when the output register is free or draining
    assign upd_go   = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);
    assign in_stall = !((state_reg == S_IDLE) || upd_go);
    assign accept   = in_valid && !in_stall;

    assign cmd.load = accept;
    assign cmd.cmp  = (state_reg == S_CMP);
    assign cmd.upd  = upd_go;

    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_go)
                    state_next = accept ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted beat always goes to compare next
    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cmd.cmp)
        else $error("accepted beat did not enter compare");

    // a commit follows a compare or a commit that was held back
    a_upd_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> ($past(cmd.cmp) || $past(state_reg == S_UPD)))
        else $error("update without a compare");

    // a commit never overwrites a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

    a_cmp_upd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cmp && cmd.upd))
        else $error("compare and update in the same cycle");

endmodule

[src/srt_datapath.sv]
`timescale 1ns / 1ps

module srt_datapath #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srt_pkg::ctrl_cmd_t cmd,
    input  srt_pkg::in_beat_t  in_beat,
    output srt_pkg::out_beat_t out_beat
);
    import srt_pkg::*;

    localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = CW + POS_W;
    localparam int RD   = (TABLE_DEPTH < (1 << POS_W)) ? TABLE_DEPTH : (1 << POS_W);

    // latched command
    action_t            act_reg;
    logic [KW-1:0]      key_reg;
    logic [GRADE_W-1:0] grade_reg;
    logic [POS_W-1:0]   pos_reg;

    // cell row, position 0 holds the largest key
    logic [KW-1:0]      cell_key_reg   [TABLE_DEPTH];
    logic [GRADE_W-1:0] cell_grade_reg [TABLE_DEPTH];
    logic [KW-1:0]      cell_key_next  [TABLE_DEPTH];
    logic [GRADE_W-1:0] cell_grade_next[TABLE_DEPTH];

    logic [CW-1:0]      count_reg, count_next;

    // per-cell compare flags
    logic [TABLE_DEPTH-1:0] gt_reg, gt_next;
    logic [TABLE_DEPTH-1:0] eq_reg, eq_next;
    logic [TABLE_DEPTH-1:0] hit;

    logic               full;
    logic               found;
    logic [GRADE_W-1:0] hit_grade;
    logic               pos_ok;
    logic [KW-1:0]      rd_key;
    logic [GRADE_W-1:0] rd_grade;
    logic               do_insert;
    logic               do_remove;
    out_beat_t          res_next;
    out_beat_t          out_reg;

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= in_beat.action;
            key_reg   <= in_beat.key[KW-1:0];
            grade_reg <= in_beat.grade;
            pos_reg   <= in_beat.position;
        end
    end

    // compare stage: each cell against the latched key
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gt_next[i] = (CW'(i) < count_reg) && (cell_key_reg[i] > key_reg);
            eq_next[i] = (CW'(i) < count_reg) && (cell_key_reg[i] == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            gt_reg <= gt_next;
            eq_reg <= eq_next;
        end
    end

    // first match sits right after the run of larger keys
    always_comb
    begin
        hit_grade = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == 0)
                hit[i] = eq_reg[i];
            else
                hit[i] = eq_reg[i] && gt_reg[(i == 0) ? 0 : i-1];
            if (hit[i])
                hit_grade = hit_grade | cell_grade_reg[i];
        end
    end

    assign found = |hit;
    assign full  = (count_reg == CW'(TABLE_DEPTH));

    // read at position
    assign pos_ok = CMPW'(pos_reg) < CMPW'(count_reg);
    always_comb
    begin
        rd_key   = '0;
        rd_grade = '0;
        for (int j = 0; j < RD; j++)
        begin
            if (pos_reg == POS_W'(j))
            begin
                rd_key   = cell_key_reg[j];
                rd_grade = cell_grade_reg[j];
            end
        end
    end

    assign do_insert = (act_reg == ACT_INSERT) && !full;
    assign do_remove = (act_reg == ACT_REMOVE) && found;

    // shift the cell row
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cell_key_next[i]   = cell_key_reg[i];
            cell_grade_next[i] = cell_grade_reg[i];
            if (do_insert && !gt_reg[i])
            begin
                if (i == 0 || gt_reg[(i == 0) ? 0 : i-1])
                begin
                    cell_key_next[i]   = key_reg;
                    cell_grade_next[i] = grade_reg;
                end
                else
                begin
                    cell_key_next[i]   = cell_key_reg[(i == 0) ? 0 : i-1];
                    cell_grade_next[i] = cell_grade_reg[(i == 0) ? 0 : i-1];
                end
            end
            else if (do_remove && !gt_reg[i] && (i < TABLE_DEPTH - 1))
            begin
                cell_key_next[i]   = cell_key_reg[(i < TABLE_DEPTH - 1) ? i+1 : i];
                cell_grade_next[i] = cell_grade_reg[(i < TABLE_DEPTH - 1) ? i+1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                cell_key_reg[i]   <= cell_key_next[i];
                cell_grade_reg[i] <= cell_grade_next[i];
            end
        end
    end

    // record count
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
            count_next = count_reg + CW'(1);
        else if (do_remove)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.upd)
            count_reg <= count_next;
    end

    // result beat
    always_comb
    begin
        res_next.status      = ST_OK;
        res_next.key_out     = '0;
        res_next.grade_out   = '0;
        res_next.entry_count = COUNT_W'(count_next);
        case (act_reg)
            ACT_INSERT:
            begin
                if (full)
                    res_next.status = ST_FULL;
            end
            ACT_REMOVE, ACT_LOOKUP:
            begin
                if (found)
                begin
                    res_next.key_out   = KEY_W'(key_reg);
                    res_next.grade_out = hit_grade;
                end
                else
                begin
                    res_next.status = ST_NOT_FOUND;
                end
            end
            ACT_READ:
            begin
                if (pos_ok)
                begin
                    res_next.key_out   = KEY_W'(rd_key);
                    res_next.grade_out = rd_grade;
                end
                else
                begin
                    res_next.status = ST_RANGE;
                end
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
            out_reg <= res_next;
    end

    assign out_beat = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    // at most one cell is the first match
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> $onehot0(hit))
        else $error("more than one first match");

    // the count moves by at most one per commit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> (count_reg == $past(count_reg)
                     || count_reg == $past(count_reg) + CW'(1)
                     || count_reg == $past(count_reg) - CW'(1)))
        else $error("record count jumped");

endmodule

[src/sorted_record_table.sv]
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// in        to block   in_valid/in_stall  in_beat   (action, key, grade, position)
// out       from block out_valid/out_stall out_beat (status, key_out, grade_out, entry_count)
//
// each beat first compares every cell against the key, then shifts the cell row
// and loads the output register
// a new beat is taken in the cycle that the previous one commits
// rst_n clears the record count and control state; the cells hold no reset value
// a stalled result holds the commit of the next beat until out_stall drops

module sorted_record_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  srt_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_stall,
    output srt_pkg::out_beat_t out_beat
);
    import srt_pkg::*;

    ctrl_cmd_t cmd;

    srt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    srt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_beat  (in_beat),
        .out_beat (out_beat)
    );

endmodule
